>>> src/atce_pkg.sv
// shared types, constants and palette functions of the text console engine
// no dependencies
package atce_pkg;

    localparam logic [23:0] FG_DEFAULT = 24'hE0E0E0;
    localparam logic [23:0] BG_DEFAULT = 24'h001A3A;
    localparam logic [13:0] X_MAX      = 14'd16383;
    localparam logic [12:0] Y_MAX      = 13'd8191;
    localparam logic [13:0] VAL_MAX    = 14'd16383;

    typedef enum logic [1:0] {
        CMD_DRAW    = 2'd0,
        CMD_SCROLL  = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_REFRESH = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NL,
        OP_CR,
        OP_TAB,
        OP_PRINT,
        OP_CLEAR,
        OP_HOME
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  code;
        logic        present;
        logic [7:0]  adv;
        logic [23:0] fg;
        logic [23:0] bg;
    } t_op;

    typedef struct packed {
        logic [13:0] region_width;
        logic [13:0] region_height;
        logic [7:0]  line_height;
        logic [7:0]  tab_unit;
        logic        backbuffer_mode;
    } t_cfg;

    function automatic logic [23:0] pal_normal(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0: c = 24'h000000;
            3'd1: c = 24'hAA0000;
            3'd2: c = 24'h00AA00;
            3'd3: c = 24'hAA5500;
            3'd4: c = 24'h5555FF;
            3'd5: c = 24'hAA00AA;
            3'd6: c = 24'h00AAAA;
            default: c = 24'hAAAAAA;
        endcase
        return c;
    endfunction

    function automatic logic [23:0] pal_bright(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0: c = 24'h555555;
            3'd1: c = 24'hFF5555;
            3'd2: c = 24'h55FF55;
            3'd3: c = 24'hFFFF55;
            3'd4: c = 24'h5555FF;
            3'd5: c = 24'hFF55FF;
            3'd6: c = 24'h55FFFF;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

endpackage

>>> src/atce_front.sv
// front end: escape parser, csi value store, sgr color walk, op classification
// depends on atce_pkg
module atce_front #(
    parameter int MAX_CSI_VALUES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enabled,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_char_byte,
    input  logic          i_glyph_present,
    input  logic [7:0]    i_glyph_advance,
    input  logic          i_q_full,
    output logic          o_push,
    output atce_pkg::t_op o_op
);
    import atce_pkg::*;

    localparam int CNT_W = $clog2(MAX_CSI_VALUES + 1);
    localparam int IDX_W = (MAX_CSI_VALUES > 1) ? $clog2(MAX_CSI_VALUES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CSI_VALUES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CSI_VALUES - 1);

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;

    typedef enum logic [1:0] {M_NORMAL, M_ESC, M_CSI} t_mode;
    typedef enum logic {F_RUN, F_SGR} t_fstate;

    t_fstate          r_st, n_st;
    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [23:0]      r_fg, n_fg, r_bg, n_bg;
    logic [13:0]      r_vals [MAX_CSI_VALUES];

    logic             accept;
    logic             v_we;
    logic [IDX_W-1:0] v_wa, rd_idx, k;
    logic [13:0]      v_wd, p, d30, d40, d90;
    logic [17:0]      prod;
    t_mode            eff_mode;
    logic [CNT_W-1:0] cnt1;

    assign o_stall = (r_st == F_SGR) || i_q_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        cnt1 = (r_count == '0) ? CNT_W'(1) : r_count;
        k    = ((cnt1 - CNT_W'(1)) >= CNT_MAX) ? IDX_LAST : IDX_W'(cnt1 - CNT_W'(1));
        rd_idx = (r_st == F_SGR) ? r_idx : k;
    end

    assign p    = r_vals[rd_idx];
    assign prod = {4'b0, p} * 18'd10 + {10'b0, i_char_byte - CH_0};
    assign d30  = p - 14'd30;
    assign d40  = p - 14'd40;
    assign d90  = p - 14'd90;

    always_comb begin
        n_st    = r_st;
        n_mode  = r_mode;
        n_count = r_count;
        n_idx   = r_idx;
        n_fg    = r_fg;
        n_bg    = r_bg;
        v_we    = 1'b0;
        v_wa    = k;
        v_wd    = '0;
        o_push  = 1'b0;
        o_op.kind    = OP_PRINT;
        o_op.code    = i_char_byte;
        o_op.present = i_glyph_present;
        o_op.adv     = i_glyph_advance;
        o_op.fg      = r_fg;
        o_op.bg      = r_bg;
        eff_mode = (r_mode == M_ESC) ? M_NORMAL : r_mode;

        if (r_st == F_SGR) begin
            if (p == 14'd0) begin
                n_fg = FG_DEFAULT;
                n_bg = BG_DEFAULT;
            end else if (p >= 14'd30 && p <= 14'd37) begin
                n_fg = pal_normal(d30[2:0]);
            end else if (p == 14'd39) begin
                n_fg = FG_DEFAULT;
            end else if (p >= 14'd40 && p <= 14'd47) begin
                n_bg = pal_normal(d40[2:0]);
            end else if (p == 14'd49) begin
                n_bg = BG_DEFAULT;
            end else if (p >= 14'd90 && p <= 14'd97) begin
                n_fg = pal_bright(d90[2:0]);
            end
            if (r_idx == IDX_W'(r_count - CNT_W'(1)) || r_idx == IDX_LAST) begin
                n_st = F_RUN;
            end
            n_idx = r_idx + IDX_W'(1);
        end else if (accept && i_enabled) begin
            if (r_mode == M_ESC && i_char_byte == CH_LBR) begin
                n_mode  = M_CSI;
                n_count = '0;
                v_we    = 1'b1;
                v_wa    = '0;
                v_wd    = '0;
            end else if (eff_mode == M_CSI) begin
                if (i_char_byte >= CH_0 && i_char_byte <= CH_9) begin
                    n_count = cnt1;
                    v_we    = 1'b1;
                    v_wd    = (prod > {4'b0, VAL_MAX}) ? VAL_MAX : prod[13:0];
                end else if (i_char_byte == CH_SEMI) begin
                    if (r_count < CNT_MAX) begin
                        v_we    = 1'b1;
                        v_wa    = IDX_W'(r_count);
                        v_wd    = '0;
                        n_count = r_count + CNT_W'(1);
                    end
                end else begin
                    n_mode = M_NORMAL;
                    if (i_char_byte == CH_M) begin
                        if (r_count == '0) begin
                            n_fg = FG_DEFAULT;
                            n_bg = BG_DEFAULT;
                        end else begin
                            n_st  = F_SGR;
                            n_idx = '0;
                        end
                    end else if (i_char_byte == CH_J) begin
                        if (r_count != '0 && r_vals[0] == 14'd2) begin
                            o_push    = 1'b1;
                            o_op.kind = OP_CLEAR;
                        end
                    end else if (i_char_byte == CH_H) begin
                        o_push    = 1'b1;
                        o_op.kind = OP_HOME;
                    end
                end
            end else begin
                n_mode = M_NORMAL;
                o_push = 1'b1;
                case (i_char_byte)
                    CH_ESC: begin
                        n_mode = M_ESC;
                        o_push = 1'b0;
                    end
                    CH_NL:   o_op.kind = OP_NL;
                    CH_CR:   o_op.kind = OP_CR;
                    CH_TAB:  o_op.kind = OP_TAB;
                    default: o_op.kind = OP_PRINT;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= F_RUN;
            r_mode  <= M_NORMAL;
            r_count <= '0;
            r_idx   <= '0;
            r_fg    <= FG_DEFAULT;
            r_bg    <= BG_DEFAULT;
        end else begin
            r_st    <= n_st;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_fg    <= n_fg;
            r_bg    <= n_bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vals[v_wa] <= v_wd;
        end
    end

endmodule

>>> src/atce_queue.sv
// two-entry op queue between the front end and the back end
// depends on atce_pkg
module atce_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  atce_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output atce_pkg::t_op o_op
);
    import atce_pkg::*;

    t_op        r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_op;
        end
    end

endmodule

>>> src/atce_back.sv
// back end: pen and line state, tab division, wrap, command output register
// depends on atce_pkg
module atce_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  atce_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  atce_pkg::t_op i_q_op,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_command,
    output logic [13:0]   o_pen_x,
    output logic [12:0]   o_line_y,
    output logic [7:0]    o_glyph_code,
    output logic [23:0]   o_fore_rgb,
    output logic [23:0]   o_back_rgb,
    output logic          o_last_of_run
);
    import atce_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_DIV, B_TABEND, B_NL, B_SCROLL, B_DRAW, B_REFRESH, B_CLEAR
    } t_bstate;

    t_bstate     r_st;
    t_op         r_op;
    logic [13:0] r_x;
    logic [12:0] r_y;
    logic        r_draw;
    logic [10:0] r_rem;
    logic [13:0] r_dq;
    logic [3:0]  r_cnt;

    logic        r_ov;
    logic [1:0]  r_cmd;
    logic [13:0] r_px;
    logic [12:0] r_ly;
    logic [7:0]  r_code;
    logic [23:0] r_fg, r_bg;
    logic        r_last;

    logic        out_free, rf;
    logic [7:0]  unit;
    logic [10:0] stop;
    logic [11:0] rs;
    logic [14:0] xs, xa, qa;
    logic [13:0] y1, ys, ynew;
    logic [14:0] y2;
    logic        scroll;

    assign out_free = !r_ov || !i_out_stall;
    assign rf       = i_cfg.backbuffer_mode && (r_op.kind == OP_NL || r_op.kind == OP_PRINT);
    assign o_pop    = (r_st == B_IDLE) && i_q_valid;

    assign unit = (i_cfg.tab_unit == 8'd0) ? 8'd1 : i_cfg.tab_unit;
    assign stop = {unit, 3'b000};
    assign rs   = {r_rem, r_dq[13]};
    assign xs   = {1'b0, r_x} - {4'b0, r_rem} + {4'b0, stop};
    assign xa   = {1'b0, r_x} + {7'b0, r_op.adv};
    assign qa   = {1'b0, r_x} + {7'b0, i_q_op.adv};

    assign y1     = {1'b0, r_y} + {6'b0, i_cfg.line_height};
    assign y2     = {1'b0, y1} + {7'b0, i_cfg.line_height};
    assign scroll = y2 > {1'b0, i_cfg.region_height};
    assign ys     = (i_cfg.region_height >= {6'b0, i_cfg.line_height}) ?
                    i_cfg.region_height - {6'b0, i_cfg.line_height} : 14'd0;
    assign ynew   = scroll ? ys : y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_x  <= '0;
            r_y  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_op   <= i_q_op;
                        r_draw <= 1'b0;
                        case (i_q_op.kind)
                            OP_NL: r_st <= B_NL;
                            OP_CR: r_x  <= '0;
                            OP_TAB: begin
                                r_rem <= '0;
                                r_dq  <= r_x;
                                r_cnt <= '0;
                                r_st  <= B_DIV;
                            end
                            OP_PRINT: begin
                                if (i_q_op.present) begin
                                    r_draw <= 1'b1;
                                    r_st   <= (qa > {1'b0, i_cfg.region_width}) ? B_NL : B_DRAW;
                                end else if (i_cfg.backbuffer_mode) begin
                                    r_st <= B_REFRESH;
                                end
                            end
                            OP_CLEAR: begin
                                r_x  <= '0;
                                r_y  <= '0;
                                r_st <= B_CLEAR;
                            end
                            OP_HOME: begin
                                r_x <= '0;
                                r_y <= '0;
                            end
                            default: r_st <= B_IDLE;
                        endcase
                    end
                end
                B_DIV: begin
                    r_rem <= (rs >= {1'b0, stop}) ? 11'(rs - {1'b0, stop}) : rs[10:0];
                    r_dq  <= {r_dq[12:0], 1'b0};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd13) begin
                        r_st <= B_TABEND;
                    end
                end
                B_TABEND: begin
                    r_x  <= (xs > {1'b0, X_MAX}) ? X_MAX : xs[13:0];
                    r_st <= ((xs > {1'b0, X_MAX} ? {1'b0, X_MAX} : xs) >=
                             {1'b0, i_cfg.region_width}) ? B_NL : B_IDLE;
                end
                B_NL: begin
                    r_x <= '0;
                    r_y <= (ynew > {1'b0, Y_MAX}) ? Y_MAX : ynew[12:0];
                    if (scroll) begin
                        r_st <= B_SCROLL;
                    end else if (r_draw) begin
                        r_st <= B_DRAW;
                    end else if (rf) begin
                        r_st <= B_REFRESH;
                    end else begin
                        r_st <= B_IDLE;
                    end
                end
                B_SCROLL, B_DRAW, B_REFRESH, B_CLEAR: begin
                    if (out_free) begin
                        r_ov   <= 1'b1;
                        r_ly   <= r_y;
                        r_fg   <= r_op.fg;
                        r_bg   <= r_op.bg;
                        r_px   <= '0;
                        r_code <= '0;
                        r_last <= 1'b1;
                        r_st   <= B_IDLE;
                        case (r_st)
                            B_SCROLL: begin
                                r_cmd  <= CMD_SCROLL;
                                r_last <= !r_draw && !rf;
                                if (r_draw) begin
                                    r_st <= B_DRAW;
                                end else if (rf) begin
                                    r_st <= B_REFRESH;
                                end
                            end
                            B_DRAW: begin
                                r_cmd  <= CMD_DRAW;
                                r_px   <= r_x;
                                r_code <= r_op.code;
                                r_last <= !rf;
                                r_x    <= (xa > {1'b0, X_MAX}) ? X_MAX : xa[13:0];
                                if (rf) begin
                                    r_st <= B_REFRESH;
                                end
                            end
                            B_REFRESH: r_cmd <= CMD_REFRESH;
                            default:   r_cmd <= CMD_CLEAR;
                        endcase
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_ov;
    assign o_command     = r_cmd;
    assign o_pen_x       = r_px;
    assign o_line_y      = r_ly;
    assign o_glyph_code  = r_code;
    assign o_fore_rgb    = r_fg;
    assign o_back_rgb    = r_bg;
    assign o_last_of_run = r_last;

    a_div_tab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == B_DIV |-> r_op.kind == OP_TAB)
        else $error("division running for a non-tab op");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == B_DIV |-> {1'b0, r_rem} < {1'b0, stop})
        else $error("tab remainder out of range");
    a_draw_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == B_DRAW |-> r_op.present && r_op.kind == OP_PRINT)
        else $error("draw without a present glyph");

endmodule

>>> src/ansi_text_console_engine.sv
// Text console engine. One character byte is accepted per request; the front end
// parses escapes at one byte per cycle while the op queue is not full and no sgr
// sequence is walking its csi values, one value per cycle. The back end takes one op
// at a time; a tab runs the 14-step shift-subtract division that finds the next tab stop.
// A two-entry op queue lets the front run ahead while commands wait on i_out_stall.
// Depends on atce_pkg, atce_front, atce_queue and atce_back.
module ansi_text_console_engine #(
    parameter int MAX_CSI_VALUES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_glyph_present,
    input  logic [7:0]  i_glyph_advance,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_command,
    output logic [13:0] o_pen_x,
    output logic [12:0] o_line_y,
    output logic [7:0]  o_glyph_code,
    output logic [23:0] o_fore_rgb,
    output logic [23:0] o_back_rgb,
    output logic        o_last_of_run
);
    import atce_pkg::*;

    localparam logic [2:0] REG_ENABLED = 3'd0;
    localparam logic [2:0] REG_WIDTH   = 3'd1;
    localparam logic [2:0] REG_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_LINE_H  = 3'd3;
    localparam logic [2:0] REG_TAB     = 3'd4;
    localparam logic [2:0] REG_BB      = 3'd5;

    logic  r_enabled;
    t_cfg  r_cfg;
    logic  wr, push, full, q_valid, pop;
    t_op   f_op, q_op;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled             <= 1'b1;
            r_cfg.region_width    <= 14'd1024;
            r_cfg.region_height   <= 14'd768;
            r_cfg.line_height     <= 8'd16;
            r_cfg.tab_unit        <= 8'd8;
            r_cfg.backbuffer_mode <= 1'b0;
        end else if (wr) begin
            case (paddr[4:2])
                REG_ENABLED: r_enabled             <= pwdata[0];
                REG_WIDTH:   r_cfg.region_width    <= pwdata[13:0];
                REG_HEIGHT:  r_cfg.region_height   <= pwdata[13:0];
                REG_LINE_H:  r_cfg.line_height     <= pwdata[7:0];
                REG_TAB:     r_cfg.tab_unit        <= pwdata[7:0];
                REG_BB:      r_cfg.backbuffer_mode <= pwdata[0];
                default:     r_enabled             <= r_enabled;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ENABLED: prdata = {31'b0, r_enabled};
            REG_WIDTH:   prdata = {18'b0, r_cfg.region_width};
            REG_HEIGHT:  prdata = {18'b0, r_cfg.region_height};
            REG_LINE_H:  prdata = {24'b0, r_cfg.line_height};
            REG_TAB:     prdata = {24'b0, r_cfg.tab_unit};
            REG_BB:      prdata = {31'b0, r_cfg.backbuffer_mode};
            default:     prdata = '0;
        endcase
    end

    atce_front #(
        .MAX_CSI_VALUES(MAX_CSI_VALUES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enabled      (r_enabled),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_char_byte    (i_char_byte),
        .i_glyph_present(i_glyph_present),
        .i_glyph_advance(i_glyph_advance),
        .i_q_full       (full),
        .o_push         (push),
        .o_op           (f_op)
    );

    atce_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (f_op),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_op   (q_op)
    );

    atce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_op       (q_op),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_command    (o_command),
        .o_pen_x      (o_pen_x),
        .o_line_y     (o_line_y),
        .o_glyph_code (o_glyph_code),
        .o_fore_rgb   (o_fore_rgb),
        .o_back_rgb   (o_back_rgb),
        .o_last_of_run(o_last_of_run)
    );

endmodule

>>> verif/ansi_text_console_engine_tb.sv
// self-checking testbench for the ansi text console engine: directed table, then random
// character streams, every result checked against a predictor kept inside the bench
// depends on atce_pkg and ansi_text_console_engine
`timescale 1ns / 100ps

module ansi_text_console_engine_tb;
    import atce_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int LONG_HOLD      = 400;
    localparam logic [4:0] REG_ENABLED = 5'd0;
    localparam logic [4:0] REG_WIDTH   = 5'd4;
    localparam logic [4:0] REG_HEIGHT  = 5'd8;
    localparam logic [4:0] REG_LINE    = 5'd12;
    localparam logic [4:0] REG_TAB     = 5'd16;
    localparam logic [4:0] REG_BACKBUF = 5'd20;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef struct {
        t_cmd        cmd;
        logic [13:0] pen;
        logic [12:0] ly;
        logic [7:0]  code;
        logic [23:0] fg;
        logic [23:0] bg;
        logic        last;
    } t_draw_cmd;

    typedef struct {
        logic [7:0] c;
        logic       p;
        logic [7:0] adv;
        bit         typed;
        t_draw_cmd  want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_char_byte = '0;
    logic        i_glyph_present = 1'b0;
    logic [7:0]  i_glyph_advance = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_command;
    logic [13:0] o_pen_x;
    logic [12:0] o_line_y;
    logic [7:0]  o_glyph_code;
    logic [23:0] o_fore_rgb;
    logic [23:0] o_back_rgb;
    logic        o_last_of_run;

    ansi_text_console_engine dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor copy of registers and console state
    int          en_r, width_r, height_r, lh_r, tab_r, bb_r;
    int          parse_st, csi_val[8], csi_n, pen_x, top_y;
    logic [23:0] fg_c, bg_c;

    t_draw_cmd   cmd_q[$];
    int          mismatches = 0;
    int          send_idle_pct = 31, recv_idle_pct = 46;
    int          hold_req = 0, hold_seen = 0, hold_left = 0;
    int          quiet_cycles = 0;
    t_row        rows[$];

    function automatic logic [23:0] palette(input int idx, input bit bright);
        logic [23:0] n[8] = '{24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
                              24'h5555FF, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA};
        logic [23:0] b[8] = '{24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
                              24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF};
        return bright ? b[idx] : n[idx];
    endfunction

    function automatic void push_cmd(ref t_draw_cmd run[$], input t_cmd cmd,
                                     input int px, input logic [7:0] code);
        t_draw_cmd r;
        r.cmd = cmd; r.pen = px[13:0]; r.ly = top_y[12:0]; r.code = code;
        r.fg = fg_c; r.bg = bg_c; r.last = 1'b0;
        run.push_back(r);
    endfunction

    function automatic void line_feed(ref t_draw_cmd run[$]);
        int y;
        y = top_y + lh_r;
        pen_x = 0;
        if (y + lh_r > height_r) begin
            y = (height_r >= lh_r) ? height_r - lh_r : 0;
            if (y > 8191) y = 8191;
            top_y = y;
            push_cmd(run, CMD_SCROLL, 0, 8'h00);
        end else begin
            if (y > 8191) y = 8191;
            top_y = y;
        end
    endfunction

    function automatic void apply_colors();
        int p;
        if (csi_n == 0) begin
            fg_c = FG_DEFAULT; bg_c = BG_DEFAULT;
        end
        for (int i = 0; i < csi_n && i < 8; i++) begin
            p = csi_val[i];
            if (p == 0) begin
                fg_c = FG_DEFAULT; bg_c = BG_DEFAULT;
            end else if (p >= 30 && p <= 37) fg_c = palette(p - 30, 0);
            else if (p == 39) fg_c = FG_DEFAULT;
            else if (p >= 40 && p <= 47) bg_c = palette(p - 40, 0);
            else if (p == 49) bg_c = BG_DEFAULT;
            else if (p >= 90 && p <= 97) fg_c = palette(p - 90, 1);
        end
    endfunction

    function automatic void predict_char(input logic [7:0] c, input logic p,
                                         input logic [7:0] adv, ref t_draw_cmd run[$]);
        int k, v, stop, x;
        run.delete();
        if (en_r == 0) return;
        if (parse_st == 1) begin
            if (c == "[") begin
                parse_st = 2; csi_n = 0; csi_val[0] = 0;
                return;
            end
            parse_st = 0;
        end
        if (parse_st == 2) begin
            if (c >= "0" && c <= "9") begin
                if (csi_n == 0) csi_n = 1;
                k = csi_n - 1;
                if (k >= 8) k = 7;
                v = csi_val[k] * 10 + (c - "0");
                csi_val[k] = v > 16383 ? 16383 : v;
                return;
            end
            if (c == ";") begin
                if (csi_n < 8) begin
                    csi_val[csi_n] = 0;
                    csi_n++;
                end
                return;
            end
            parse_st = 0;
            if (c == "m") apply_colors();
            else if (c == "J") begin
                if (csi_n > 0 && csi_val[0] == 2) begin
                    pen_x = 0; top_y = 0;
                    push_cmd(run, CMD_CLEAR, 0, 8'h00);
                end
            end else if (c == "H") begin
                pen_x = 0; top_y = 0;
            end
        end else if (c == CH_ESC) parse_st = 1;
        else if (c == CH_NL) begin
            line_feed(run);
            if (bb_r != 0) push_cmd(run, CMD_REFRESH, 0, 8'h00);
        end else if (c == CH_CR) pen_x = 0;
        else if (c == CH_TAB) begin
            stop = (tab_r != 0 ? tab_r : 1) * 8;
            x = (pen_x / stop + 1) * stop;
            pen_x = x > 16383 ? 16383 : x;
            if (pen_x >= width_r) line_feed(run);
        end else begin
            if (p) begin
                if (pen_x + adv > width_r) line_feed(run);
                push_cmd(run, CMD_DRAW, pen_x, c);
                x = pen_x + adv;
                pen_x = x > 16383 ? 16383 : x;
            end
            if (bb_r != 0) push_cmd(run, CMD_REFRESH, 0, 8'h00);
        end
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic p, input logic [7:0] adv,
                             input bit typed = 0,
                             input t_draw_cmd want = '{cmd: CMD_DRAW, default: 0});
        t_draw_cmd run[$];
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_byte <= c;
        i_glyph_present <= p;
        i_glyph_advance <= adv;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
        predict_char(c, p, adv, run);
        if (typed && run.size() > 0) run[0] = want;
        foreach (run[i]) cmd_q.push_back(run[i]);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [4:0] addr, input int val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (addr)
            REG_ENABLED: en_r = val & 1;
            REG_WIDTH:   width_r = val & 16'h3FFF;
            REG_HEIGHT:  height_r = val & 16'h3FFF;
            REG_LINE:    lh_r = val & 8'hFF;
            REG_TAB:     tab_r = val & 8'hFF;
            REG_BACKBUF: bb_r = val & 1;
            default: ;
        endcase
    endtask

    task automatic set_layout(input int w, input int h, input int lh, input int tu,
                              input int bb);
        drain();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_LINE, lh);
        reg_write(REG_TAB, tu);
        reg_write(REG_BACKBUF, bb);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b1, 8'($urandom_range(12)));
    endtask

    function automatic int sgr_value();
        case ($urandom_range(7))
            0: return 0;
            1: return 30 + $urandom_range(7);
            2: return 40 + $urandom_range(7);
            3: return 90 + $urandom_range(7);
            4: return $urandom_range(1) ? 39 : 49;
            5: return $urandom_range(120);
            default: return $urandom_range(30, 47);
        endcase
    endfunction

    task automatic random_request(ref int n);
        int    pick, cnt;
        string s;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_char(8'($urandom_range(32, 126)), $urandom_range(9) != 0,
                      $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(16)));
            n++;
        end else if (pick < 40) begin
            send_char(CH_NL, 1'($urandom_range(1)), 8'($urandom)); n++;
        end else if (pick < 45) begin
            send_char(CH_CR, 1'($urandom_range(1)), 8'($urandom)); n++;
        end else if (pick < 52) begin
            send_char(CH_TAB, 1'($urandom_range(1)), 8'($urandom)); n++;
        end else if (pick < 72) begin
            cnt = $urandom_range(10);
            s = "\033[";
            for (int i = 0; i < cnt; i++) begin
                if (i > 0) s = {s, ";"};
                s = {s, $sformatf("%0d", sgr_value())};
            end
            s = {s, "m"};
            send_text(s);
            n += s.len();
        end else if (pick < 78) begin
            case ($urandom_range(3))
                0: s = "\033[2J";
                1: s = "\033[H";
                2: s = $sformatf("\033[%0dJ", $urandom_range(4));
                default: s = "\033[2;5J";
            endcase
            send_text(s);
            n += s.len();
        end else if (pick < 84) begin
            send_char(CH_ESC, 1'b1, 8'($urandom));
            send_char(8'($urandom), 1'($urandom_range(1)), 8'($urandom));
            n += 2;
        end else if (pick < 88) begin
            s = $sformatf("\033[%0d;%0dm", $urandom_range(99999, 9999999),
                          $urandom_range(30, 37));
            send_text(s);
            n += s.len();
        end else begin
            send_char(8'($urandom), 1'($urandom_range(1)), 8'($urandom)); n++;
        end
    endtask

    task automatic random_phase(input int target);
        int n;
        n = 0;
        while (n < target) random_request(n);
    endtask

    function automatic t_row mk(input logic [7:0] c, input logic p, input logic [7:0] adv);
        t_row r;
        r = '{c: c, p: p, adv: adv, typed: 0, want: '{cmd: CMD_DRAW, default: 0}};
        return r;
    endfunction

    // output check on the stable half of the cycle
    initial begin
        t_draw_cmd w;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t unexpected command %0d", $time, o_command);
                    mismatches++;
                end else begin
                    w = cmd_q.pop_front();
                    if (o_command !== w.cmd || o_pen_x !== w.pen || o_line_y !== w.ly ||
                        o_glyph_code !== w.code || o_fore_rgb !== w.fg ||
                        o_back_rgb !== w.bg || o_last_of_run !== w.last) begin
                        $display("%0t mismatch exp cmd %0d x %0d y %0d code %h fg %h bg %h l %b",
                                 $time, w.cmd, w.pen, w.ly, w.code, w.fg, w.bg, w.last);
                        $display("%0t          got cmd %0d x %0d y %0d code %h fg %h bg %h l %b",
                                 $time, o_command, o_pen_x, o_line_y, o_glyph_code,
                                 o_fore_rgb, o_back_rgb, o_last_of_run);
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver back pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_row  r;
        string seq;
        en_r = 1; width_r = 1024; height_r = 768; lh_r = 16; tab_r = 8; bb_r = 0;
        parse_st = 0; csi_n = 0; pen_x = 0; top_y = 0;
        foreach (csi_val[i]) csi_val[i] = 0;
        fg_c = FG_DEFAULT; bg_c = BG_DEFAULT;

        r = mk("A", 1, 8);
        r.typed = 1;
        r.want = '{CMD_DRAW, 14'd0, 13'd0, 8'h41, FG_DEFAULT, BG_DEFAULT, 1'b1};
        rows.push_back(r);
        rows.push_back(mk("B", 0, 8'hFF));
        rows.push_back(mk(8'h01, 1, 8'd255));
        rows.push_back(mk(8'hFF, 1, 8'd255));
        rows.push_back(mk(CH_ESC, 1, 0));
        rows.push_back(mk("[", 1, 0));
        rows.push_back(mk("2", 1, 0));
        r = mk("J", 1, 0);
        r.typed = 1;
        r.want = '{CMD_CLEAR, 14'd0, 13'd0, 8'h00, FG_DEFAULT, BG_DEFAULT, 1'b1};
        rows.push_back(r);
        rows.push_back(mk(CH_TAB, 0, 0));
        rows.push_back(mk(CH_CR, 0, 0));
        rows.push_back(mk(CH_NL, 0, 0));
        rows.push_back(mk(CH_ESC, 0, 0));
        rows.push_back(mk("x", 1, 3));
        seq = "\033[44;97m";
        foreach (seq[i]) rows.push_back(mk(seq[i], 1, 0));
        rows.push_back(mk("C", 1, 8'd0));
        seq = "\033[m";
        foreach (seq[i]) rows.push_back(mk(seq[i], 1, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_char(rows[i].c, rows[i].p, rows[i].adv,
                                    rows[i].typed, rows[i].want);
        send_text("\033[99999;31m\033[1;2;3;4;5;6;7;8;9;44mX\033[5XY\033[H");

        random_phase(50);
        set_layout(8192, 8192, 255, 255, 1);
        random_phase(50);
        set_layout(1, 1, 1, 1, 0);
        random_phase(50);

        send_idle_pct = 46; recv_idle_pct = 31;
        set_layout(100, 40, 16, 2, 1);
        hold_req++;
        for (int i = 0; i < 30; i++) send_char(8'($urandom_range(33, 126)), 1'b1, 8'd7);
        drain();
        random_phase(50);

        drain();
        reg_write(REG_ENABLED, 0);
        for (int i = 0; i < 10; i++) send_char(8'($urandom), 1'b1, 8'($urandom));
        drain();
        reg_write(REG_ENABLED, 1);

        send_idle_pct = 0; recv_idle_pct = 0;
        set_layout(8192, 60, 20, 1, 0);
        random_phase(50);
        set_layout($urandom_range(1, 300), $urandom_range(40, 200), $urandom_range(1, 40),
                   $urandom_range(1, 20), $urandom_range(1));
        random_phase(50);

        drain();
        if (mismatches == 0 && cmd_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/atce_pkg.sv
src/atce_front.sv
src/atce_queue.sv
src/atce_back.sv
src/ansi_text_console_engine.sv
verif/ansi_text_console_engine_tb.sv
